FILE: rtl/urc_pkg.sv
package urc_pkg;

  // Field widths
  localparam int unsigned INTERVAL_W   = 20;
  localparam int unsigned TRIG_W       = 8;
  localparam int unsigned TIMEOUT_W    = 20;
  localparam int unsigned DIST_W       = 19;
  localparam int unsigned DUR_W        = 16;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned PROD_W       = 32;

  // Default timestamp width
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Register reset values
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST    = 20'd60000;
  localparam logic [TRIG_W-1:0]     TRIG_HIGH_RST   = 8'd2;
  localparam logic [TRIG_W-1:0]     TRIG_END_RST    = 8'd12;
  localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RST     = 20'd50000;
  localparam logic [DIST_W-1:0]     TIMEOUT_DIST_RST = 19'd102400;
  localparam logic [DIST_W-1:0]     OBSTACLE_RST    = 19'd5120;
  localparam logic [DIST_W-1:0]     DIST_RST        = 19'd76800;

  // Distance scaling: q8 = (dur * 43904 + 5000) / 10000
  localparam logic [PROD_W-1:0]     DIST_MULT       = 32'd43904;
  localparam logic [PROD_W-1:0]     DIST_BIAS       = 32'd5000;
  // ceil(2^45 / 10000), exact for every numerator below 2^32
  localparam logic [PROD_W-1:0]     DIV_RECIP       = 32'd3518437209;
  localparam int unsigned           DIV_SHIFT       = 45;
  localparam logic [DUR_W-1:0]      DUR_MAX         = 16'hFFFF;
  localparam logic [DIST_W-1:0]     DIST_MAX        = 19'd287725;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_HIGH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_DIST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE   = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval_us;
    logic [TRIG_W-1:0]     trig_high_start_us;
    logic [TRIG_W-1:0]     trig_end_us;
    logic [TIMEOUT_W-1:0]  timeout_us;
    logic [DIST_W-1:0]     timeout_distance;
    logic [DIST_W-1:0]     obstacle_limit;
  } cfg_t;

  // Per-tick result flags carried down the pipeline
  typedef struct packed {
    logic trig;
    logic done;
    logic tmo;
    logic upd;
  } flags_t;

endpackage

FILE: rtl/urc_if.sv
interface urc_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink   (input valid, input echo_level, output ready);
endinterface

interface urc_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_level;
  logic [18:0] distance_q8;
  logic        measure_done;
  logic        timed_out;
  logic        obstacle_near;

  modport source (output valid, output trigger_level, output distance_q8,
                  output measure_done, output timed_out, output obstacle_near,
                  input ready);
  modport sink   (input valid, input trigger_level, input distance_q8,
                  input measure_done, input timed_out, input obstacle_near,
                  output ready);
endinterface

interface urc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/urc_cfg_regs.sv
module urc_cfg_regs
  import urc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  urc_cfg_if.sink    cfg,
  output cfg_t       regs
);

  logic wr;

  // Always take a write transaction
  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid;

  // Decode index and store masked data
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.interval_us        <= INTERVAL_RST;
      regs.trig_high_start_us <= TRIG_HIGH_RST;
      regs.trig_end_us        <= TRIG_END_RST;
      regs.timeout_us         <= TIMEOUT_RST;
      regs.timeout_distance   <= TIMEOUT_DIST_RST;
      regs.obstacle_limit     <= OBSTACLE_RST;
    end else if (wr) begin
      case (cfg.index)
        CFG_INTERVAL:     regs.interval_us        <= cfg.data[INTERVAL_W-1:0];
        CFG_TRIG_HIGH:    regs.trig_high_start_us <= cfg.data[TRIG_W-1:0];
        CFG_TRIG_END:     regs.trig_end_us        <= cfg.data[TRIG_W-1:0];
        CFG_TIMEOUT:      regs.timeout_us         <= cfg.data[TIMEOUT_W-1:0];
        CFG_TIMEOUT_DIST: regs.timeout_distance   <= cfg.data[DIST_W-1:0];
        CFG_OBSTACLE:     regs.obstacle_limit     <= cfg.data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/urc_sequencer.sv
module urc_sequencer
  import urc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  urc_in_if.sink           tick,
  input  cfg_t             regs,
  input  logic             down_ready,
  output logic             s1_valid,
  output flags_t           s1_flags,
  output logic [DUR_W-1:0] s1_dur
);

  localparam int unsigned PAD_I = TIME_WIDTH - INTERVAL_W;
  localparam int unsigned PAD_T = TIME_WIDTH - TRIG_W;
  localparam int unsigned PAD_O = TIME_WIDTH - TIMEOUT_W;
  localparam int unsigned PAD_D = TIME_WIDTH - DUR_W;

  logic s0_valid;
  logic s0_echo;
  logic s1_ready;
  logic step;

  // Sequencer state
  phase_t                phase, phase_next;
  logic [TIME_WIDTH-1:0] tick_count;
  logic [TIME_WIDTH-1:0] start_time, start_time_next;
  logic [TIME_WIDTH-1:0] rise_time, rise_time_next;
  logic [TIME_WIDTH-1:0] fall_time, fall_time_next;
  logic [TIME_WIDTH-1:0] last_done, last_done_next;
  logic                  prev_echo;
  logic                  pending, pending_next;
  logic                  trig, trig_next;

  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH-1:0] since_done;
  logic [TIME_WIDTH-1:0] dur_raw;
  logic [DUR_W-1:0]      dur_sat;
  flags_t                flags;

  assign s1_ready   = !s1_valid || down_ready;
  assign tick.ready = !s0_valid || s1_ready;
  assign step       = s0_valid && s1_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (tick.ready) begin
      s0_valid <= tick.valid;
    end
    if (tick.valid && tick.ready) begin
      s0_echo <= tick.echo_level;
    end
  end

  assign elapsed    = tick_count - start_time;
  assign since_done = tick_count - last_done;

  // Next state and per-tick flags
  always_comb begin
    phase_next      = phase;
    start_time_next = start_time;
    rise_time_next  = rise_time;
    fall_time_next  = fall_time;
    last_done_next  = last_done;
    pending_next    = pending;
    trig_next       = trig;
    flags           = '0;

    // Track echo edges in every phase
    if (s0_echo && !prev_echo) begin
      rise_time_next = tick_count;
    end
    if (!s0_echo && prev_echo) begin
      fall_time_next = tick_count;
      pending_next   = 1'b1;
    end

    case (phase)
      PH_TRIG: begin
        if (elapsed >= {{PAD_T{1'b0}}, regs.trig_high_start_us}) begin
          trig_next = 1'b1;
        end
        if (elapsed >= {{PAD_T{1'b0}}, regs.trig_end_us}) begin
          trig_next       = 1'b0;
          start_time_next = tick_count;
          phase_next      = PH_WAIT;
        end
      end
      PH_WAIT: begin
        // Timeout takes priority over an echo on the same tick
        if (elapsed > {{PAD_O{1'b0}}, regs.timeout_us}) begin
          flags.tmo  = 1'b1;
          flags.done = 1'b1;
        end else if (pending_next) begin
          flags.upd    = 1'b1;
          flags.done   = 1'b1;
          pending_next = 1'b0;
        end
        if (flags.done) begin
          last_done_next = tick_count;
          phase_next     = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
        if (since_done >= {{PAD_I{1'b0}}, regs.interval_us}) begin
          trig_next       = 1'b0;
          start_time_next = tick_count;
          phase_next      = PH_TRIG;
        end
      end
    endcase

    flags.trig = trig_next;
  end

  // Saturate the echo duration
  assign dur_raw = fall_time_next - rise_time_next;
  assign dur_sat = (dur_raw > {{PAD_D{1'b0}}, DUR_MAX}) ? DUR_MAX : dur_raw[DUR_W-1:0];

  // Phase register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  // Timestamps and flags of the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      start_time <= '0;
      rise_time  <= '0;
      fall_time  <= '0;
      last_done  <= '0;
      prev_echo  <= 1'b0;
      pending    <= 1'b0;
      trig       <= 1'b0;
    end else if (step) begin
      tick_count <= tick_count + 1'b1;
      start_time <= start_time_next;
      rise_time  <= rise_time_next;
      fall_time  <= fall_time_next;
      last_done  <= last_done_next;
      prev_echo  <= s0_echo;
      pending    <= pending_next;
      trig       <= trig_next;
    end
  end

  // Result stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= s0_valid;
    end
    if (step) begin
      s1_flags <= flags;
      s1_dur   <= dur_sat;
    end
  end

endmodule

FILE: rtl/urc_scale.sv
module urc_scale
  import urc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  input  flags_t            up_flags,
  input  logic [DUR_W-1:0]  up_dur,
  output logic              up_ready,
  output logic              dn_valid,
  output flags_t            dn_flags,
  output logic [DIST_W-1:0] dn_dist,
  input  logic              down_ready
);

  logic                  s2_valid;
  flags_t                s2_flags;
  logic [PROD_W-1:0]     s2_num;
  logic                  s2_ready;
  logic                  s3_ready;
  logic [PROD_W-1:0]     num;
  logic [2*PROD_W-1:0]   prod;

  assign s3_ready = !dn_valid || down_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign up_ready = s2_ready;

  // Scale duration into the rounded numerator
  assign num = {{(PROD_W-DUR_W){1'b0}}, up_dur} * DIST_MULT + DIST_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= up_valid;
    end
    if (s2_ready && up_valid) begin
      s2_flags <= up_flags;
      s2_num   <= num;
    end
  end

  // Divide by 10000 through the reciprocal
  assign prod = {{PROD_W{1'b0}}, s2_num} * {{PROD_W{1'b0}}, DIV_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (s3_ready) begin
      dn_valid <= s2_valid;
    end
    if (s3_ready && s2_valid) begin
      dn_flags <= s2_flags;
      dn_dist  <= prod[DIV_SHIFT +: DIST_W];
    end
  end

endmodule

FILE: rtl/ultrasonic_ranging_controller.sv
// Ultrasonic echo ranging controller.
// tick: one transaction per microsecond, carrying the sampled echo pin level.
// result: one transaction per tick with the trigger pin level, the latest
//   distance in 1/256 cm, a completion flag, a timeout flag and a near flag.
// cfg: register writes (index 0..5), always ready; write only while idle.
// Pipeline: a tick transaction passes the input register, sequencer stage, scale
//   multiply, reciprocal divide multiply and output register in order.
// Throughput: one tick per cycle while result is taken; every stage is a single
//   register stage and the sequencer state updates once per tick.
// Reset: sequencer idle, all timestamps zero, distance 300 cm, registers at
//   their defaults, no result pending.
// Stall: when result is not taken, the stages fill and tick.ready drops once
//   the input register is occupied; no transaction is lost or repeated.
module ultrasonic_ranging_controller
  import urc_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  urc_in_if.sink     tick,
  urc_out_if.source  result,
  urc_cfg_if.sink    cfg
);

  cfg_t              regs;
  logic              s1_valid;
  flags_t            s1_flags;
  logic [DUR_W-1:0]  s1_dur;
  logic              s1_ready;
  logic              s3_valid;
  flags_t            s3_flags;
  logic [DIST_W-1:0] s3_dist;
  logic              out_free;
  logic [DIST_W-1:0] dist_next;

  urc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  urc_sequencer #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .regs       (regs),
    .down_ready (s1_ready),
    .s1_valid   (s1_valid),
    .s1_flags   (s1_flags),
    .s1_dur     (s1_dur)
  );

  urc_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s1_valid),
    .up_flags   (s1_flags),
    .up_dur     (s1_dur),
    .up_ready   (s1_ready),
    .dn_valid   (s3_valid),
    .dn_flags   (s3_flags),
    .dn_dist    (s3_dist),
    .down_ready (out_free)
  );

  assign out_free = !result.valid || result.ready;

  // Select the new held distance
  always_comb begin
    dist_next = result.distance_q8;
    if (s3_flags.tmo) begin
      dist_next = regs.timeout_distance;
    end else if (s3_flags.upd) begin
      dist_next = s3_dist;
    end
  end

  // Output register; the distance field holds the latest distance
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid       <= 1'b0;
      result.distance_q8 <= DIST_RST;
    end else if (out_free) begin
      result.valid <= s3_valid;
      if (s3_valid) begin
        result.distance_q8 <= dist_next;
      end
    end
    if (out_free && s3_valid) begin
      result.trigger_level <= s3_flags.trig;
      result.measure_done  <= s3_flags.done;
      result.timed_out     <= s3_flags.tmo;
      result.obstacle_near <= dist_next < regs.obstacle_limit;
    end
  end

  // A timeout is always a completion
  a_tmo_done: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (!result.timed_out || result.measure_done))
    else $error("timeout without completion");

  // An echo completion never exceeds the saturated range
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.measure_done && !result.timed_out)
      |-> (result.distance_q8 <= DIST_MAX))
    else $error("echo distance out of range");

  // Near flag follows the held distance
  a_near: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.obstacle_near == (result.distance_q8 < regs.obstacle_limit)))
    else $error("obstacle flag mismatch");

endmodule
